// ----- design/cbc_pkg.sv -----
// Shared constants and types for the color blob centroid block.
package cbc_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned CoordW = 11;
  localparam int unsigned HitW   = 21;
  localparam int unsigned SumW   = 30;
  localparam int unsigned ProdW  = CoordW + HitW;
  localparam int unsigned QuoW   = CoordW;
  localparam int unsigned DivW   = HitW + 1;

  localparam int unsigned NumRegs  = 7;
  localparam int unsigned RegIdxW  = $clog2(NumRegs + 1);
  localparam int unsigned AddrW    = RegIdxW + 2;
  localparam int unsigned DataW    = 32;

  typedef enum logic [RegIdxW-1:0] {
    RegLumaLow     = 3'd0,
    RegLumaHigh    = 3'd1,
    RegBlueLow     = 3'd2,
    RegBlueHigh    = 3'd3,
    RegRedLow      = 3'd4,
    RegRedHigh     = 3'd5,
    RegMarkEnable  = 3'd6
  } cbc_reg_e;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StPrep = 5'b00100,
    StDiv  = 5'b01000,
    StEmit = 5'b10000
  } cbc_state_e;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quotient;
  } cbc_div_res_t;

endpackage

// ----- design/cbc_pix_if.sv -----
// Pixel input channel.
interface cbc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] blue_diff;
  logic [7:0] red_diff;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, luma, blue_diff, red_diff, line_end, frame_end, input ready);
  modport sink   (input valid, luma, blue_diff, red_diff, line_end, frame_end, output ready);
endinterface

// ----- design/cbc_res_if.sv -----
// Result channel: pixel passthrough and frame summary.
interface cbc_res_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         luma_out;
  logic               matched;
  logic [20:0]        match_total;
  logic signed [10:0] centre_x;
  logic signed [10:0] centre_y;
  logic               overflow;
  logic               last;

  modport source (output valid, kind, luma_out, matched, match_total, centre_x, centre_y,
                  overflow, last, input ready);
  modport sink   (input valid, kind, luma_out, matched, match_total, centre_x, centre_y,
                  overflow, last, output ready);
endinterface

// ----- design/cbc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module cbc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [cbc_pkg::ProdW-1:0]          dividend_i,
  input  logic [cbc_pkg::DivW-1:0]           divisor_i,
  output cbc_pkg::cbc_div_res_t              res_o
);
  import cbc_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ProdW-1:0]    rem_q, rem_d;
  logic [ProdW-1:0]    dsh_q, dsh_d;
  logic [QuoW-1:0]     quo_q, quo_d;
  logic                fits;

  assign fits = rem_q >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuoW - 1);
      rem_d  = dividend_i;
      dsh_d  = ProdW'({divisor_i, {(QuoW-1){1'b0}}});
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QuoW-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;

endmodule

// ----- design/color_blob_centroid_core.sv -----
// Color threshold blob centroid: top level with counters, sequencer and config port.
//
// Pixels stream in raster order; each ordinary pixel yields one passthrough transfer.
// The frame_end pixel yields its passthrough and then a summary, after StMul, StPrep
// and StDiv have run for the x axis and again for the y axis and StEmit has waited
// out any result-side stall: one shared 11x21 multiplier and one 11-step divider
// serve both axes, and no pixel is taken meanwhile.
// Config registers sit at byte address 4*i and are written in the APB access phase.
module color_blob_centroid_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbc_pix_if.sink                       pix_i,
  cbc_res_if.source                     res_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [cbc_pkg::AddrW-1:0]     paddr_i,
  input  logic [cbc_pkg::DataW-1:0]     pwdata_i,
  output logic [cbc_pkg::DataW-1:0]     prdata_o,
  output logic                          pready_o
);
  import cbc_pkg::*;

  localparam logic [CoordW-1:0] MaxW = CoordW'(MaxWidth);
  localparam logic [CoordW-1:0] MaxH = CoordW'(MaxHeight);

  // config registers
  logic [7:0] luma_low_q, luma_high_q, blue_low_q, blue_high_q, red_low_q, red_high_q;
  logic       mark_q;
  logic       cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = paddr_i[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_low_q  <= '0;
      luma_high_q <= '0;
      blue_low_q  <= '0;
      blue_high_q <= '0;
      red_low_q   <= '0;
      red_high_q  <= '0;
      mark_q      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegLumaLow:    luma_low_q  <= pwdata_i[7:0];
        RegLumaHigh:   luma_high_q <= pwdata_i[7:0];
        RegBlueLow:    blue_low_q  <= pwdata_i[7:0];
        RegBlueHigh:   blue_high_q <= pwdata_i[7:0];
        RegRedLow:     red_low_q   <= pwdata_i[7:0];
        RegRedHigh:    red_high_q  <= pwdata_i[7:0];
        RegMarkEnable: mark_q      <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegLumaLow:    prdata_o = DataW'(luma_low_q);
      RegLumaHigh:   prdata_o = DataW'(luma_high_q);
      RegBlueLow:    prdata_o = DataW'(blue_low_q);
      RegBlueHigh:   prdata_o = DataW'(blue_high_q);
      RegRedLow:     prdata_o = DataW'(red_low_q);
      RegRedHigh:    prdata_o = DataW'(red_high_q);
      RegMarkEnable: prdata_o = DataW'(mark_q);
      default:       prdata_o = '0;
    endcase
  end

  // state
  cbc_state_e        state_q, state_d;
  logic              axis_q, axis_d;
  logic [CoordW-1:0] column_q, column_d, row_q, row_d;
  logic [CoordW-1:0] width_q, width_d, height_q, height_d;
  logic [HitW-1:0]   hit_q, hit_d;
  logic [SumW-1:0]   csum_q, csum_d, rsum_q, rsum_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;

  // datapath registers
  logic [ProdW-1:0]  prod_q;
  logic              neg_q;
  logic [CoordW-1:0] cx_q, cy_q;
  logic              load_pix, load_sum;

  logic               o_kind_q, o_matched_q, o_ovf_q, o_last_q;
  logic [7:0]         o_luma_q;
  logic [HitW-1:0]    o_total_q;
  logic [CoordW-1:0]  o_cx_q, o_cy_q;

  logic slot_free, accept, match, in_frame;

  assign slot_free   = !out_valid_q || res_o.ready;
  assign pix_i.ready = (state_q == StIdle) && slot_free;
  assign accept      = pix_i.valid && pix_i.ready;

  assign match = (pix_i.luma >= luma_low_q) && (pix_i.luma <= luma_high_q) &&
                 (pix_i.blue_diff >= blue_low_q) && (pix_i.blue_diff <= blue_high_q) &&
                 (pix_i.red_diff >= red_low_q) && (pix_i.red_diff <= red_high_q);
  assign in_frame = (column_q < MaxW) && (row_q < MaxH);

  // shared divider
  logic               div_start;
  logic [32:0]        diff;
  logic [ProdW-1:0]   mag;
  logic [ProdW-1:0]   dividend;
  cbc_div_res_t       div_res;
  logic [QuoW-1:0]    signed_q;

  always_comb begin
    if (axis_q) begin
      diff = {1'b0, prod_q} - {2'b00, rsum_q, 1'b0};
    end else begin
      diff = {2'b00, csum_q, 1'b0} - {1'b0, prod_q};
    end
  end
  assign mag      = diff[32] ? ProdW'(-diff) : diff[ProdW-1:0];
  assign dividend = mag + ProdW'(hit_q);
  assign div_start = (state_q == StPrep);
  assign signed_q = neg_q ? (~div_res.quotient + 1'b1) : div_res.quotient;

  cbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  ({hit_q, 1'b0}),
    .res_o      (div_res)
  );

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    column_d    = column_q;
    row_d       = row_q;
    width_d     = width_q;
    height_d    = height_q;
    hit_d       = hit_q;
    csum_d      = csum_q;
    rsum_d      = rsum_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !res_o.ready;
    load_pix    = 1'b0;
    load_sum    = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          load_pix    = 1'b1;
          out_valid_d = 1'b1;
          if (!in_frame) begin
            ovf_d = 1'b1;
          end
          if (match && in_frame) begin
            hit_d  = hit_q + 1'b1;
            csum_d = csum_q + SumW'(column_q);
            rsum_d = rsum_q + SumW'(row_q);
          end
          if ((pix_i.line_end || pix_i.frame_end) && row_q == '0) begin
            width_d = (column_q < MaxW) ? column_q + 1'b1 : MaxW;
          end
          if (pix_i.frame_end) begin
            height_d = (row_q < MaxH) ? row_q + 1'b1 : MaxH;
            column_d = '0;
            row_d    = '0;
            axis_d   = 1'b0;
            state_d  = StMul;
          end else if (pix_i.line_end) begin
            column_d = '0;
            if (row_q < MaxH) begin
              row_d = row_q + 1'b1;
            end
          end else if (column_q < MaxW) begin
            column_d = column_q + 1'b1;
          end
        end
      end
      StMul:  state_d = StPrep;
      StPrep: state_d = StDiv;
      StDiv: begin
        if (div_res.done) begin
          if (axis_q) begin
            state_d = StEmit;
          end else begin
            axis_d  = 1'b1;
            state_d = StMul;
          end
        end
      end
      StEmit: begin
        if (slot_free) begin
          load_sum    = 1'b1;
          out_valid_d = 1'b1;
          width_d     = '0;
          height_d    = '0;
          hit_d       = '0;
          csum_d      = '0;
          rsum_d      = '0;
          ovf_d       = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= 1'b0;
      column_q    <= '0;
      row_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      hit_q       <= '0;
      csum_q      <= '0;
      rsum_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      column_q    <= column_d;
      row_q       <= row_d;
      width_q     <= width_d;
      height_q    <= height_d;
      hit_q       <= hit_d;
      csum_q      <= csum_d;
      rsum_q      <= rsum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StMul) begin
      prod_q <= (axis_q ? height_q : width_q) * hit_q;
    end
    if (state_q == StPrep) begin
      neg_q <= diff[32];
    end
    if (state_q == StDiv && div_res.done) begin
      if (axis_q) begin
        cy_q <= signed_q;
      end else begin
        cx_q <= signed_q;
      end
    end
    if (load_pix) begin
      o_kind_q    <= 1'b0;
      o_luma_q    <= (match && mark_q) ? 8'hFF : pix_i.luma;
      o_matched_q <= match;
      o_total_q   <= '0;
      o_cx_q      <= '0;
      o_cy_q      <= '0;
      o_ovf_q     <= 1'b0;
      o_last_q    <= !pix_i.frame_end;
    end else if (load_sum) begin
      o_kind_q    <= 1'b1;
      o_luma_q    <= '0;
      o_matched_q <= 1'b0;
      o_total_q   <= hit_q;
      o_cx_q      <= (hit_q == '0) ? '0 : cx_q;
      o_cy_q      <= (hit_q == '0) ? '0 : cy_q;
      o_ovf_q     <= ovf_q;
      o_last_q    <= 1'b1;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = o_kind_q;
  assign res_o.luma_out    = o_luma_q;
  assign res_o.matched     = o_matched_q;
  assign res_o.match_total = o_total_q;
  assign res_o.centre_x    = o_cx_q;
  assign res_o.centre_y    = o_cy_q;
  assign res_o.overflow    = o_ovf_q;
  assign res_o.last        = o_last_q;

endmodule

// ----- design/cbc_checker.sv -----
// Port-level assertions for the color blob centroid core, with bind.
module cbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pix_valid,
  input logic        pix_ready,
  input logic        pix_frame_end,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_kind,
  input logic [7:0]  res_luma_out,
  input logic        res_matched,
  input logic [20:0] res_match_total,
  input logic [10:0] res_centre_x,
  input logic [10:0] res_centre_y,
  input logic        res_overflow,
  input logic        res_last
);

  a_frame_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && pix_ready && pix_frame_end |=> !pix_ready)
    else $error("pixel taken right after frame end");

  a_summary_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_kind |-> res_last && res_luma_out == 8'd0 && !res_matched)
    else $error("malformed summary");

  a_pixel_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_kind |->
      res_match_total == 21'd0 && res_centre_x == 11'd0 && res_centre_y == 11'd0 &&
      !res_overflow)
    else $error("pixel result carries summary fields");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_last))
    else $error("result dropped before transfer");

endmodule

bind color_blob_centroid_core cbc_checker u_cbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid       (pix_i.valid),
  .pix_ready       (pix_i.ready),
  .pix_frame_end   (pix_i.frame_end),
  .res_valid       (res_o.valid),
  .res_ready       (res_o.ready),
  .res_kind        (res_o.kind),
  .res_luma_out    (res_o.luma_out),
  .res_matched     (res_o.matched),
  .res_match_total (res_o.match_total),
  .res_centre_x    (res_o.centre_x),
  .res_centre_y    (res_o.centre_y),
  .res_overflow    (res_o.overflow),
  .res_last        (res_o.last)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for color_blob_centroid_core: directed and random raster frames against a predictor.
module tb;
  import cbc_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RandomItems  = 900;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned DrainCycles  = 64;
  localparam int unsigned UnusedRegIdx = NumRegs;
  localparam int unsigned BigWidth     = MaxWidth + 2;
  localparam int unsigned BigHeight    = MaxHeight + 2;
  localparam logic        KindPixel    = 1'b0;
  localparam logic        KindSummary  = 1'b1;

  typedef enum int unsigned {RxOpen, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       line_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        luma_out;
    logic              matched;
    logic [HitW-1:0]   match_total;
    logic [CoordW-1:0] centre_x;
    logic [CoordW-1:0] centre_y;
    logic              overflow;
    logic              last;
  } result_t;

  class centroid_scoreboard;
    result_t           expected_q[$];
    logic [7:0]        bound[NumRegs-1];
    logic              mark;
    logic [CoordW-1:0] column, row, frame_width;
    logic [HitW-1:0]   hit_count;
    logic [SumW-1:0]   column_sum, row_sum;
    logic              size_ovf;
    int unsigned       errors, summaries, hits;

    function new();
      foreach (bound[i]) bound[i] = 8'h00;
      mark      = 1'b0;
      errors    = 0;
      summaries = 0;
      hits      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      column      = '0;
      row         = '0;
      frame_width = '0;
      hit_count   = '0;
      column_sum  = '0;
      row_sum     = '0;
      size_ovf    = 1'b0;
    endfunction

    function void set_reg(int unsigned idx, logic [DataW-1:0] value);
      if (idx == RegMarkEnable) mark = value[0];
      else if (idx < NumRegs) bound[idx] = value[7:0];
    endfunction

    function bit in_band(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
      return (v >= lo) && (v <= hi);
    endfunction

    // half away from zero, den > 0
    function logic [CoordW-1:0] round_centre(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return CoordW'((num < 0) ? -q : q);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_pixel(pixel_t p);
      bit      in_frame, hit;
      result_t px, sm;
      longint  n, h, nx, ny;
      in_frame = (column < MaxWidth) && (row < MaxHeight);
      hit = in_band(p.luma, bound[RegLumaLow], bound[RegLumaHigh]) &&
            in_band(p.blue_diff, bound[RegBlueLow], bound[RegBlueHigh]) &&
            in_band(p.red_diff, bound[RegRedLow], bound[RegRedHigh]);
      if (hit) hits++;
      if (!in_frame) size_ovf = 1'b1;
      if (hit && in_frame) begin
        hit_count++;
        column_sum += column;
        row_sum    += row;
      end
      px          = '0;
      px.kind     = KindPixel;
      px.luma_out = (hit && mark) ? 8'hFF : p.luma;
      px.matched  = hit;
      px.last     = !p.frame_end;
      expected_q.push_back(px);
      if ((p.line_end || p.frame_end) && row == 0)
        frame_width = (column < MaxWidth) ? CoordW'(column + 1) : CoordW'(MaxWidth);
      if (p.frame_end) begin
        h  = (row < MaxHeight) ? longint'(row) + 1 : MaxHeight;
        sm = '0;
        sm.kind        = KindSummary;
        sm.match_total = hit_count;
        if (hit_count != 0) begin
          n  = longint'(hit_count);
          nx = 2 * longint'(column_sum) - longint'(frame_width) * n;
          ny = h * n - 2 * longint'(row_sum);
          sm.centre_x = round_centre(nx, 2 * n);
          sm.centre_y = round_centre(ny, 2 * n);
        end
        sm.overflow = size_ovf;
        sm.last     = 1'b1;
        expected_q.push_back(sm);
        summaries++;
        clear_frame();
      end else if (p.line_end) begin
        column = '0;
        if (row < MaxHeight) row++;
      end else if (column < MaxWidth) begin
        column++;
      end
    endfunction

    function int unsigned field_bad(string name, logic signed [31:0] e, logic signed [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing pending (kind %0d)", act.kind);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      errors += field_bad("kind", exp.kind, act.kind);
      errors += field_bad("luma_out", exp.luma_out, act.luma_out);
      errors += field_bad("matched", exp.matched, act.matched);
      errors += field_bad("match_total", exp.match_total, act.match_total);
      errors += field_bad("centre_x", $signed(exp.centre_x), $signed(act.centre_x));
      errors += field_bad("centre_y", $signed(exp.centre_y), $signed(act.centre_y));
      errors += field_bad("overflow", exp.overflow, act.overflow);
      errors += field_bad("last", exp.last, act.last);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel_i, penable_i, pwrite_i;
  logic [AddrW-1:0] paddr_i;
  logic [DataW-1:0] pwdata_i;
  logic [DataW-1:0] prdata_o;
  logic             pready_o;

  cbc_pix_if pix ();
  cbc_res_if res ();

  color_blob_centroid_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_o     (res),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  centroid_scoreboard sb = new();

  pixel_t      stim_q[$];
  pixel_t      phase_q[$];
  pixel_t      drive_item;
  result_t     seen;
  logic [7:0]  cfg_bound[NumRegs-1];
  logic        cfg_mark;
  int unsigned pushed, accepted, settings, cycles;
  int unsigned gap_left, burst_left;
  int unsigned rx_stretch, rx_phase;
  rx_mode_e    rx_mode;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $error("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("[color_blob_centroid_core] ERROR");
      $finish;
    end
  end

  // pixel sender: bursts and gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        sb.note_pixel(drive_item);
        accepted++;
      end
      if (!pix.valid || pix.ready) begin
        if (gap_left > 0 || stim_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          pix.valid <= 1'b0;
        end else begin
          drive_item = stim_q.pop_front();
          pix.valid     <= 1'b1;
          pix.luma      <= drive_item.luma;
          pix.blue_diff <= drive_item.blue_diff;
          pix.red_diff  <= drive_item.red_diff;
          pix.line_end  <= drive_item.line_end;
          pix.frame_end <= drive_item.frame_end;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap_left   = $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // result receiver: stall pattern changes over random stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 3));
        rx_stretch = $urandom_range(4, 80);
      end
      rx_stretch--;
      rx_phase++;
      case (rx_mode)
        RxOpen:   res.ready <= 1'b1;
        RxCoin:   res.ready <= 1'($urandom_range(0, 1));
        RxSparse: res.ready <= ($urandom_range(0, 4) == 0);
        default:  res.ready <= rx_phase[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      seen.kind        = res.kind;
      seen.luma_out    = res.luma_out;
      seen.matched     = res.matched;
      seen.match_total = res.match_total;
      seen.centre_x    = res.centre_x;
      seen.centre_y    = res.centre_y;
      seen.overflow    = res.overflow;
      seen.last        = res.last;
      sb.check_result(seen);
    end
  end

  task automatic reg_write(int unsigned idx, logic [DataW-1:0] value);
    logic [DataW-1:0] word;
    word = ($urandom() & ~32'hFF) | (value & 32'hFF);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= AddrW'(idx * 4);
    pwdata_i  <= word;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    sb.set_reg(idx, word);
  endtask

  task automatic apply_config();
    for (int i = RegLumaLow; i <= RegRedHigh; i++) reg_write(i, DataW'(cfg_bound[i]));
    reg_write(RegMarkEnable, (32'($urandom_range(0, 127)) << 1) | cfg_mark);
    reg_write(UnusedRegIdx, $urandom());
    settings++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (pushed != accepted || sb.pending() != 0);
  endtask

  // optional mid-stream hold: sender stops until all results have drained
  task automatic run_phase(bit pause);
    int unsigned split;
    split = (pause && phase_q.size() > 1) ? $urandom_range(1, phase_q.size() - 1)
                                          : phase_q.size();
    foreach (phase_q[i]) begin
      if (i == split) wait_idle();
      stim_q.push_back(phase_q[i]);
      pushed++;
    end
    wait_idle();
    phase_q.delete();
  endtask

  function automatic void push_px(logic [7:0] y, logic [7:0] cb, logic [7:0] cr,
                                  logic le, logic fe);
    pixel_t p;
    p.luma      = y;
    p.blue_diff = cb;
    p.red_diff  = cr;
    p.line_end  = le;
    p.frame_end = fe;
    phase_q.push_back(p);
  endfunction

  function automatic logic [7:0] pick_sample(int unsigned axis);
    logic [7:0] lo, hi;
    lo = cfg_bound[2 * axis];
    hi = cfg_bound[2 * axis + 1];
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom());
      default: return (lo <= hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom());
    endcase
  endfunction

  function automatic void gen_frame(int unsigned w, int unsigned h);
    pixel_t      p;
    int unsigned len;
    bit          ragged, broken;
    ragged = ($urandom_range(0, 3) == 0);
    broken = ($urandom_range(0, 9) == 0);
    p = '0;
    for (int unsigned r = 0; r < h; r++) begin
      len = (r == 0 || !ragged) ? w : $urandom_range(1, w + 2);
      for (int unsigned c = 0; c < len; c++) begin
        // 4:2:2 pairs share chroma, with occasional odd pairs
        if (c % 2 == 0 || $urandom_range(0, 7) == 0) begin
          p.blue_diff = pick_sample(1);
          p.red_diff  = pick_sample(2);
        end
        p.luma      = pick_sample(0);
        p.frame_end = (r == h - 1) && (c == len - 1);
        p.line_end  = (c == len - 1) && !(broken && $urandom_range(0, 2) == 0);
        if (p.frame_end) p.line_end = 1'($urandom_range(0, 1));
        phase_q.push_back(p);
      end
    end
  endfunction

  function automatic void set_bounds(logic [7:0] lo, logic [7:0] hi);
    for (int a = 0; a < 3; a++) begin
      cfg_bound[2 * a]     = lo;
      cfg_bound[2 * a + 1] = hi;
    end
  endfunction

  initial begin
    int unsigned axis;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    psel_i     = 1'b0;
    penable_i  = 1'b0;
    pwrite_i   = 1'b0;
    paddr_i    = '0;
    pwdata_i   = '0;
    pix.valid     = 1'b0;
    pix.luma      = '0;
    pix.blue_diff = '0;
    pix.red_diff  = '0;
    pix.line_end  = 1'b0;
    pix.frame_end = 1'b0;
    res.ready     = 1'b0;
    set_bounds(8'h00, 8'h00);
    cfg_mark = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: only black matches; single-pixel frame hits both half cases
    push_px(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    push_px(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    run_phase(1'b0);

    // full range, marking on, ragged lines
    set_bounds(8'h00, 8'hFF);
    cfg_mark = 1'b1;
    apply_config();
    push_px(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    push_px(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    push_px(8'h80, 8'h00, 8'hFF, 1'b0, 1'b0);
    push_px(8'h07, 8'hFF, 8'h00, 1'b0, 1'b0);
    push_px(8'h01, 8'h02, 8'h03, 1'b1, 1'b0);
    push_px(8'h09, 8'h09, 8'h09, 1'b0, 1'b1);
    run_phase(1'b0);

    // crossed luma and Cr bounds never match
    cfg_bound = '{8'd200, 8'd100, 8'd0, 8'd255, 8'd255, 8'd0};
    apply_config();
    push_px(8'd150, 8'd10, 8'd10, 1'b0, 1'b0);
    push_px(8'd200, 8'd128, 8'd128, 1'b0, 1'b0);
    push_px(8'd100, 8'd0, 8'd255, 1'b1, 1'b1);
    run_phase(1'b0);

    // single-value bounds, one step off on each side
    cfg_bound = '{8'd10, 8'd10, 8'd20, 8'd20, 8'd30, 8'd30};
    apply_config();
    push_px(8'd10, 8'd20, 8'd30, 1'b0, 1'b0);
    push_px(8'd11, 8'd20, 8'd30, 1'b0, 1'b0);
    push_px(8'd10, 8'd21, 8'd30, 1'b0, 1'b0);
    push_px(8'd10, 8'd20, 8'd31, 1'b1, 1'b0);
    push_px(8'd9, 8'd20, 8'd30, 1'b0, 1'b0);
    push_px(8'd10, 8'd19, 8'd29, 1'b0, 1'b1);
    run_phase(1'b0);

    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      cfg_mark = 1'($urandom_range(0, 1));
      case (ph % 5)
        0: begin
          for (int a = 0; a < 6; a += 2) begin
            cfg_bound[a]     = 8'($urandom());
            cfg_bound[a + 1] = 8'($urandom_range(cfg_bound[a], 255));
          end
        end
        1: begin
          set_bounds(8'h00, 8'hFF);
          cfg_mark = 1'b1;
        end
        2: begin
          set_bounds(8'h00, 8'hFF);
          axis = $urandom_range(0, 2);
          cfg_bound[2 * axis]     = 8'($urandom_range(1, 255));
          cfg_bound[2 * axis + 1] = 8'($urandom_range(0, cfg_bound[2 * axis] - 1));
        end
        3: begin
          set_bounds(8'h00, 8'h00);
          cfg_mark = 1'b1;
        end
        default: begin
          set_bounds(8'hFF, 8'hFF);
          cfg_mark = 1'b0;
        end
      endcase
      apply_config();
      while (phase_q.size() < RandomItems / RandomPhases)
        gen_frame(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16),
                  $urandom_range(1, 8));
      run_phase(1'b1);
    end

    // oversized frame: either a first line past the width limit or rows past the height limit
    set_bounds(8'h00, 8'hFF);
    cfg_mark = 1'($urandom_range(0, 1));
    apply_config();
    if ($urandom_range(0, 1) == 0) begin
      for (int unsigned c = 0; c < BigWidth; c++)
        push_px(8'($urandom()), 8'($urandom()), 8'($urandom()), c == BigWidth - 1, 1'b0);
      push_px(8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1, 1'b1);
    end else begin
      for (int unsigned r = 0; r < BigHeight; r++)
        push_px(8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1, r == BigHeight - 1);
    end
    run_phase(1'b1);

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d pixels in %0d frames over %0d register settings; %0d pixels matched.",
             accepted, sb.summaries, settings, sb.hits);
    $display("Frames included ragged, merged, crossed-bound and oversized cases.");
    if (sb.errors == 0) begin
      $display("[color_blob_centroid_core] OK");
    end else begin
      $display("[color_blob_centroid_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cbc_pkg.sv
design/cbc_pix_if.sv
design/cbc_res_if.sv
design/cbc_div.sv
design/color_blob_centroid_core.sv
design/cbc_checker.sv
tb/tb.sv
